[rtl/core/tnrxneg_pkg.sv]
// Shared types, protocol codes and reply tables for the telnet receive negotiator.
package tnrxneg_pkg;

   localparam int SUB_CAPACITY = 256;
   localparam int SUB_CNT_W    = $clog2(SUB_CAPACITY + 1);

   localparam logic [7:0] TN_IAC  = 8'd255;
   localparam logic [7:0] TN_SE   = 8'd240;
   localparam logic [7:0] TN_SB   = 8'd250;
   localparam logic [7:0] TN_WILL = 8'd251;
   localparam logic [7:0] TN_WONT = 8'd252;
   localparam logic [7:0] TN_DO   = 8'd253;
   localparam logic [7:0] TN_DONT = 8'd254;

   localparam logic [7:0] OPT_ECHO   = 8'd1;
   localparam logic [7:0] OPT_SGA    = 8'd3;
   localparam logic [7:0] OPT_TTYPE  = 8'd24;
   localparam logic [7:0] OPT_NEWENV = 8'd39;

   localparam logic [7:0] SUB_IS   = 8'd0;
   localparam logic [7:0] SUB_SEND = 8'd1;

   // Terminal type answer, framed as IAC SB TERMINAL-TYPE IS <name> IAC SE.
   localparam logic [7:0] TTYPE_REPLY [16] = '{
      8'hFF, 8'hFA, 8'h18, 8'h00,
      8'h44, 8'h45, 8'h43, 8'h2D, 8'h56, 8'h54, 8'h32, 8'h34, 8'h30,
      8'hFF, 8'hF0, 8'h00
   };

   // Empty environment answer: IAC SB NEW-ENVIRON IS IAC SE.
   localparam logic [7:0] ENV_REPLY [8] = '{
      8'hFF, 8'hFA, 8'h27, 8'h00, 8'hFF, 8'hF0, 8'h00, 8'h00
   };

   typedef enum logic [7:0] {
      PS_TEXT   = 8'b0000_0001,
      PS_IAC    = 8'b0000_0010,
      PS_WILL   = 8'b0000_0100,
      PS_WONT   = 8'b0000_1000,
      PS_DO     = 8'b0001_0000,
      PS_DONT   = 8'b0010_0000,
      PS_SB     = 8'b0100_0000,
      PS_SB_IAC = 8'b1000_0000
   } parse_state_type;

   typedef enum logic [1:0] {
      KIND_TEXT  = 2'd0,
      KIND_VERB  = 2'd1,
      KIND_TTYPE = 2'd2,
      KIND_ENV   = 2'd3
   } rsp_kind_type;

   // Index of the final byte of a result run.
   function automatic logic [3:0] kind_last_idx(input rsp_kind_type kind);
      logic [3:0] n;
      case (kind)
         KIND_TEXT:  n = 4'd0;
         KIND_VERB:  n = 4'd2;
         KIND_TTYPE: n = 4'd14;
         KIND_ENV:   n = 4'd5;
         default:    n = 4'd0;
      endcase
      return n;
   endfunction

   function automatic logic [7:0] kind_byte(input rsp_kind_type kind,
                                            input logic [3:0]   idx,
                                            input logic [7:0]   verb,
                                            input logic [7:0]   data);
      logic [7:0] b;
      case (kind)
         KIND_TEXT: b = data;
         KIND_VERB: begin
            case (idx)
               4'd0:    b = TN_IAC;
               4'd1:    b = verb;
               default: b = data;
            endcase
         end
         KIND_TTYPE: b = TTYPE_REPLY[idx];
         KIND_ENV:   b = ENV_REPLY[idx[2:0]];
         default:    b = data;
      endcase
      return b;
   endfunction

endpackage

[rtl/core/telnet_receive_negotiator.sv]
// Telnet receive negotiator: parses received bytes and emits terminal data and replies.
//
// One received byte enters per item. Plain text, a doubled IAC and every byte that
// produces nothing are taken at one item per clock. A byte that causes results loads
// a single output register that then sends the run one byte per clock unless the
// output stalls: 1 byte for a text byte, 3 bytes for a WILL/WONT/DO/DONT answer, 6
// for the environment subnegotiation answer and 15 for the terminal type answer. The
// next item is taken in the same cycle that the final byte of a run leaves, so input
// stalls only while a multi-byte run is in progress or the output side stalls.
module telnet_receive_negotiator (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_rx_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_to_network,
   output logic       rsp_last
);
   import tnrxneg_pkg::*;

   parse_state_type        state_ff, state_in;
   logic [SUB_CNT_W-1:0]   sub_count_ff, sub_count_in;
   logic [7:0]             sub_option_ff, sub_option_in;
   logic [7:0]             sub_second_ff, sub_second_in;

   logic                   valid_ff, valid_in;
   rsp_kind_type           kind_ff, kind_in;
   logic [7:0]             verb_ff, verb_in;
   logic [7:0]             data_ff, data_in;
   logic [3:0]             idx_ff, idx_in;

   logic                   accept;
   logic                   out_fire;
   logic                   out_done;
   logic                   produce;
   logic [7:0]             c;
   logic                   will_ok;
   logic                   do_ok;

   assign rsp_last       = (idx_ff == kind_last_idx(kind_ff));
   assign rsp_valid      = valid_ff;
   assign rsp_out_byte   = kind_byte(kind_ff, idx_ff, verb_ff, data_ff);
   assign rsp_to_network = (kind_ff != KIND_TEXT);

   assign out_fire  = valid_ff && !rsp_stall;
   assign out_done  = out_fire && rsp_last;
   assign req_stall = valid_ff && !out_done;
   assign accept    = req_valid && !req_stall;

   assign c       = req_rx_byte;
   assign will_ok = (c == OPT_ECHO) || (c == OPT_SGA) || (c == OPT_TTYPE);
   assign do_ok   = will_ok || (c == OPT_NEWENV);

   always_comb begin
      state_in      = state_ff;
      sub_count_in  = sub_count_ff;
      sub_option_in = sub_option_ff;
      sub_second_in = sub_second_ff;
      produce       = 1'b0;
      kind_in       = KIND_TEXT;
      verb_in       = TN_DO;
      data_in       = c;

      case (state_ff)
         PS_TEXT: begin
            if (c == TN_IAC) begin
               state_in = PS_IAC;
            end else begin
               produce = 1'b1;
            end
         end
         PS_IAC: begin
            case (c)
               TN_IAC: begin
                  state_in = PS_TEXT;
                  produce  = 1'b1;
               end
               TN_WILL: state_in = PS_WILL;
               TN_WONT: state_in = PS_WONT;
               TN_DO:   state_in = PS_DO;
               TN_DONT: state_in = PS_DONT;
               TN_SB: begin
                  state_in      = PS_SB;
                  sub_count_in  = '0;
                  sub_option_in = 8'd0;
                  sub_second_in = 8'd0;
               end
               default: state_in = PS_TEXT;
            endcase
         end
         PS_WILL: begin
            state_in = PS_TEXT;
            produce  = 1'b1;
            kind_in  = KIND_VERB;
            verb_in  = will_ok ? TN_DO : TN_DONT;
         end
         PS_WONT: begin
            state_in = PS_TEXT;
            produce  = 1'b1;
            kind_in  = KIND_VERB;
            verb_in  = TN_DONT;
         end
         PS_DO: begin
            state_in = PS_TEXT;
            produce  = 1'b1;
            kind_in  = KIND_VERB;
            verb_in  = do_ok ? TN_WILL : TN_WONT;
         end
         PS_DONT: begin
            state_in = PS_TEXT;
            produce  = 1'b1;
            kind_in  = KIND_VERB;
            verb_in  = TN_WONT;
         end
         PS_SB: begin
            if (c == TN_IAC) begin
               state_in = PS_SB_IAC;
            end else if (sub_count_ff < SUB_CNT_W'(SUB_CAPACITY)) begin
               if (sub_count_ff == '0) begin
                  sub_option_in = c;
               end else if (sub_count_ff == SUB_CNT_W'(1)) begin
                  sub_second_in = c;
               end
               sub_count_in = sub_count_ff + SUB_CNT_W'(1);
            end
         end
         PS_SB_IAC: begin
            // Anything but SE is dropped and the subnegotiation stays open.
            if (c == TN_SE) begin
               state_in = PS_TEXT;
               if ((sub_count_ff >= SUB_CNT_W'(2)) && (sub_second_ff == SUB_SEND)) begin
                  if ((sub_option_ff == OPT_TTYPE) && (sub_count_ff == SUB_CNT_W'(2))) begin
                     produce = 1'b1;
                     kind_in = KIND_TTYPE;
                  end else if (sub_option_ff == OPT_NEWENV) begin
                     produce = 1'b1;
                     kind_in = KIND_ENV;
                  end
               end
            end
         end
         default: state_in = PS_TEXT;
      endcase
   end

   always_comb begin
      valid_in = valid_ff;
      idx_in   = idx_ff;
      if (accept) begin
         valid_in = produce;
         idx_in   = 4'd0;
      end else if (out_fire) begin
         valid_in = !rsp_last;
         idx_in   = idx_ff + 4'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= PS_TEXT;
         sub_count_ff  <= '0;
         sub_option_ff <= 8'd0;
         sub_second_ff <= 8'd0;
         valid_ff      <= 1'b0;
         idx_ff        <= 4'd0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
         if (accept) begin
            state_ff      <= state_in;
            sub_count_ff  <= sub_count_in;
            sub_option_ff <= sub_option_in;
            sub_second_ff <= sub_second_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept && produce) begin
         kind_ff <= kind_in;
         verb_ff <= verb_in;
         data_ff <= data_in;
      end
   end

   a_idx_in_run: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> (idx_ff <= kind_last_idx(kind_ff)))
      else $error("run index beyond end of result run");

   a_text_pass: assert property (@(posedge clock) disable iff (reset)
      (accept && (state_ff == PS_TEXT) && (req_rx_byte != TN_IAC))
         |=> (rsp_valid && !rsp_to_network && rsp_last
              && (rsp_out_byte == $past(req_rx_byte))))
      else $error("text byte not passed to terminal");

   a_sub_cap: assert property (@(posedge clock) disable iff (reset)
      sub_count_ff <= SUB_CNT_W'(SUB_CAPACITY))
      else $error("subnegotiation count above capacity");

   a_run_holds_input: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && !rsp_last) |-> req_stall)
      else $error("input taken during an unfinished run");

endmodule

[verif/telnet_receive_negotiator_test.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the telnet receive negotiator: scripted bytes, then random streams.
module telnet_receive_negotiator_test;
   import tnrxneg_pkg::*;

   localparam int         CLK_HALF     = 6;
   localparam int         RESET_CYCLES = 12;
   localparam int         RANDOM_ITEMS = 72;
   localparam int         QUIET_ITEMS  = 20;
   localparam int         HOLD_CYCLES  = 200;
   localparam int         DRAIN_CYCLES = 32;
   localparam int         CYCLE_LIMIT  = 600000;
   localparam int         OPENING_LEN  = 31;
   localparam logic [7:0] CMD_NOP      = 8'd241;
   localparam logic       TO_TERM      = 1'b0;
   localparam logic       TO_NET       = 1'b1;

   // Terminal type that the block reports in its subnegotiation answer.
   localparam logic [7:0] TERM_ID [9] = '{
      8'h44, 8'h45, 8'h43, 8'h2D, 8'h56, 8'h54, 8'h32, 8'h34, 8'h30
   };

   typedef struct packed {
      logic [7:0] out_byte;
      logic       to_net;
      logic       last;
   } result_type;

   typedef struct packed {
      logic [7:0] rx;
      logic       typed;
      logic [7:0] out_byte;
      logic       to_net;
   } opening_row_type;

   logic       clock       = 1'b0;
   logic       reset       = 1'b1;
   logic       req_valid   = 1'b0;
   logic       req_stall;
   logic [7:0] req_rx_byte = 8'h00;
   logic       rsp_valid;
   logic       rsp_stall   = 1'b0;
   logic [7:0] rsp_out_byte;
   logic       rsp_to_network;
   logic       rsp_last;

   // Scripted opening. Typed rows carry their one expected result; the rest use the predictor.
   opening_row_type opening [OPENING_LEN] = '{
      '{8'h00,      1'b1, 8'h00,  TO_TERM},
      '{TN_IAC,     1'b0, 8'h00,  TO_TERM},
      '{TN_IAC,     1'b1, TN_IAC, TO_TERM},
      '{TN_IAC,     1'b0, 8'h00,  TO_TERM},
      '{CMD_NOP,    1'b0, 8'h00,  TO_TERM},
      '{TN_IAC,     1'b0, 8'h00,  TO_TERM},
      '{TN_WILL,    1'b0, 8'h00,  TO_TERM},
      '{OPT_ECHO,   1'b0, 8'h00,  TO_TERM},
      '{TN_IAC,     1'b0, 8'h00,  TO_TERM},
      '{TN_WONT,    1'b0, 8'h00,  TO_TERM},
      '{OPT_SGA,    1'b0, 8'h00,  TO_TERM},
      '{TN_IAC,     1'b0, 8'h00,  TO_TERM},
      '{TN_DO,      1'b0, 8'h00,  TO_TERM},
      '{OPT_NEWENV, 1'b0, 8'h00,  TO_TERM},
      '{TN_IAC,     1'b0, 8'h00,  TO_TERM},
      '{TN_DONT,    1'b0, 8'h00,  TO_TERM},
      '{TN_IAC,     1'b0, 8'h00,  TO_TERM},
      '{TN_IAC,     1'b0, 8'h00,  TO_TERM},
      '{TN_SB,      1'b0, 8'h00,  TO_TERM},
      '{OPT_TTYPE,  1'b0, 8'h00,  TO_TERM},
      '{SUB_SEND,   1'b0, 8'h00,  TO_TERM},
      '{TN_IAC,     1'b0, 8'h00,  TO_TERM},
      '{TN_SE,      1'b0, 8'h00,  TO_TERM},
      '{TN_IAC,     1'b0, 8'h00,  TO_TERM},
      '{TN_SB,      1'b0, 8'h00,  TO_TERM},
      '{OPT_NEWENV, 1'b0, 8'h00,  TO_TERM},
      '{SUB_SEND,   1'b0, 8'h00,  TO_TERM},
      '{TN_IAC,     1'b0, 8'h00,  TO_TERM},
      '{CMD_NOP,    1'b0, 8'h00,  TO_TERM},
      '{TN_IAC,     1'b0, 8'h00,  TO_TERM},
      '{TN_SE,      1'b0, 8'h00,  TO_TERM}
   };

   parse_state_type        neg_state = PS_TEXT;
   logic [SUB_CNT_W-1:0]   sb_count  = '0;
   logic [7:0]             sb_opt    = 8'h00;
   logic [7:0]             sb_second = 8'h00;

   result_type step_out [$];
   result_type expected_q [$];
   logic [7:0] pending_bytes [$];

   bit quiet        = 1'b0;
   bit hold_req     = 1'b0;
   bit sender_idles = 1'b1;
   int fails           = 0;
   int items_sent      = 0;
   int results_checked = 0;
   int net_results     = 0;
   int cycles          = 0;

   telnet_receive_negotiator dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_rx_byte    (req_rx_byte),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_to_network (rsp_to_network),
      .rsp_last       (rsp_last)
   );

   always #CLK_HALF clock = ~clock;

   function automatic void emit(input logic [7:0] b, input logic net);
      result_type r;
      r.out_byte = b;
      r.to_net   = net;
      r.last     = 1'b0;
      step_out.push_back(r);
   endfunction

   function automatic void answer(input logic [7:0] verb, input logic [7:0] opt);
      emit(TN_IAC, TO_NET);
      emit(verb, TO_NET);
      emit(opt, TO_NET);
   endfunction

   function automatic void close_sub();
      int i;
      if (sb_count >= 2 && sb_second == SUB_SEND) begin
         if (sb_opt == OPT_TTYPE && sb_count == 2) begin
            emit(TN_IAC, TO_NET);
            emit(TN_SB, TO_NET);
            emit(OPT_TTYPE, TO_NET);
            emit(SUB_IS, TO_NET);
            for (i = 0; i < 9; i++)
               emit(TERM_ID[i], TO_NET);
            emit(TN_IAC, TO_NET);
            emit(TN_SE, TO_NET);
         end else if (sb_opt == OPT_NEWENV) begin
            emit(TN_IAC, TO_NET);
            emit(TN_SB, TO_NET);
            emit(OPT_NEWENV, TO_NET);
            emit(SUB_IS, TO_NET);
            emit(TN_IAC, TO_NET);
            emit(TN_SE, TO_NET);
         end
      end
   endfunction

   // Advances the parser copy by one received byte and leaves its results in step_out.
   function automatic void predict_byte(input logic [7:0] c);
      step_out.delete();
      case (neg_state)
         PS_TEXT: begin
            if (c == TN_IAC)
               neg_state = PS_IAC;
            else
               emit(c, TO_TERM);
         end
         PS_IAC: begin
            if (c == TN_IAC) begin
               neg_state = PS_TEXT;
               emit(c, TO_TERM);
            end else if (c == TN_WILL) begin
               neg_state = PS_WILL;
            end else if (c == TN_WONT) begin
               neg_state = PS_WONT;
            end else if (c == TN_DO) begin
               neg_state = PS_DO;
            end else if (c == TN_DONT) begin
               neg_state = PS_DONT;
            end else if (c == TN_SB) begin
               neg_state = PS_SB;
               sb_count  = '0;
               sb_opt    = 8'h00;
               sb_second = 8'h00;
            end else begin
               neg_state = PS_TEXT;
            end
         end
         PS_WILL: begin
            neg_state = PS_TEXT;
            if (c == OPT_ECHO || c == OPT_SGA || c == OPT_TTYPE)
               answer(TN_DO, c);
            else
               answer(TN_DONT, c);
         end
         PS_WONT: begin
            neg_state = PS_TEXT;
            answer(TN_DONT, c);
         end
         PS_DO: begin
            neg_state = PS_TEXT;
            if (c == OPT_ECHO || c == OPT_SGA || c == OPT_TTYPE || c == OPT_NEWENV)
               answer(TN_WILL, c);
            else
               answer(TN_WONT, c);
         end
         PS_DONT: begin
            neg_state = PS_TEXT;
            answer(TN_WONT, c);
         end
         PS_SB: begin
            if (c == TN_IAC) begin
               neg_state = PS_SB_IAC;
            end else if (sb_count < SUB_CAPACITY) begin
               if (sb_count == 0)
                  sb_opt = c;
               else if (sb_count == 1)
                  sb_second = c;
               sb_count = sb_count + 1'b1;
            end
         end
         PS_SB_IAC: begin
            // Anything but SE is dropped and the parser keeps waiting for SE.
            if (c == TN_SE) begin
               neg_state = PS_TEXT;
               close_sub();
            end
         end
         default: neg_state = PS_TEXT;
      endcase
   endfunction

   task automatic offer_byte(input logic [7:0] b, input logic typed,
                             input logic [7:0] t_out, input logic t_net);
      int         gap;
      int         i;
      result_type r;
      gap = 0;
      if (!quiet && sender_idles && $urandom_range(0, 5) == 0)
         gap = $urandom_range(1, 14);
      if (gap > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      do @(posedge clock); while (req_stall);
      predict_byte(b);
      items_sent++;
      if (typed) begin
         r.out_byte = t_out;
         r.to_net   = t_net;
         r.last     = 1'b1;
         expected_q.push_back(r);
      end else begin
         for (i = 0; i < step_out.size(); i++) begin
            r      = step_out[i];
            r.last = (i == step_out.size() - 1);
            expected_q.push_back(r);
         end
      end
   endtask

   task automatic send_pending();
      int i;
      for (i = 0; i < pending_bytes.size(); i++)
         offer_byte(pending_bytes[i], 1'b0, 8'h00, TO_TERM);
   endtask

   task automatic drain_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_q.size() != 0)
         @(posedge clock);
   endtask

   function automatic logic [7:0] pick_option();
      logic [7:0] b;
      case ($urandom_range(0, 7))
         0:       b = OPT_ECHO;
         1:       b = OPT_SGA;
         2:       b = OPT_TTYPE;
         3:       b = OPT_NEWENV;
         default: b = 8'($urandom_range(0, 255));
      endcase
      return b;
   endfunction

   function automatic logic [7:0] pick_verb();
      logic [7:0] b;
      case ($urandom_range(0, 3))
         0:       b = TN_WILL;
         1:       b = TN_WONT;
         2:       b = TN_DO;
         default: b = TN_DONT;
      endcase
      return b;
   endfunction

   // Mostly well-formed command streams with random content, plus some raw noise.
   function automatic void build_stream();
      int         sel;
      int         n;
      int         i;
      logic [7:0] b;
      pending_bytes.delete();
      sel = $urandom_range(0, 99);
      if (sel < 30) begin
         n = $urandom_range(1, 8);
         for (i = 0; i < n; i++)
            pending_bytes.push_back(8'($urandom_range(0, 254)));
         if ($urandom_range(0, 7) == 0) begin
            pending_bytes.push_back(TN_IAC);
            pending_bytes.push_back(TN_IAC);
         end
      end else if (sel < 55) begin
         pending_bytes.push_back(TN_IAC);
         pending_bytes.push_back(pick_verb());
         pending_bytes.push_back(pick_option());
      end else if (sel < 65) begin
         pending_bytes.push_back(TN_IAC);
         pending_bytes.push_back(8'($urandom_range(0, 249)));
      end else if (sel < 90) begin
         pending_bytes.push_back(TN_IAC);
         pending_bytes.push_back(TN_SB);
         sel = $urandom_range(0, 9);
         if (sel == 0)
            n = $urandom_range(0, 1);
         else if (sel < 6)
            n = 2;
         else
            n = $urandom_range(3, 6);
         for (i = 0; i < n; i++) begin
            if (i == 0) begin
               sel = $urandom_range(0, 9);
               b = (sel < 5) ? OPT_TTYPE : (sel < 8) ? OPT_NEWENV : 8'($urandom_range(0, 254));
            end else if (i == 1) begin
               b = ($urandom_range(0, 9) < 7) ? SUB_SEND : 8'($urandom_range(0, 254));
            end else begin
               b = 8'($urandom_range(0, 254));
            end
            pending_bytes.push_back(b);
            // A stray command inside the block freezes the count until SE.
            if ($urandom_range(0, 11) == 0) begin
               pending_bytes.push_back(TN_IAC);
               pending_bytes.push_back(8'($urandom_range(0, 239)));
            end
         end
         pending_bytes.push_back(TN_IAC);
         pending_bytes.push_back(TN_SE);
      end else begin
         n = $urandom_range(1, 4);
         for (i = 0; i < n; i++)
            pending_bytes.push_back(8'($urandom_range(0, 255)));
      end
   endfunction

   // Result side: random stall bursts, calm stretches, and one long hold-off on request.
   initial begin : result_side
      int stall_left;
      int run_left;
      stall_left = 0;
      run_left   = 0;
      forever begin
         @(negedge clock);
         if (hold_req) begin
            hold_req   = 1'b0;
            stall_left = HOLD_CYCLES;
         end
         if (stall_left > 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else if (quiet) begin
            rsp_stall <= 1'b0;
         end else if (run_left > 0) begin
            rsp_stall <= 1'b0;
            run_left--;
         end else begin
            rsp_stall  <= 1'b1;
            stall_left = $urandom_range(1, 14) - 1;
            run_left   = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 120)
                                                     : $urandom_range(0, 6);
         end
      end
   end

   always @(posedge clock) begin : watch_results
      result_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (expected_q.size() == 0) begin
            $error("unexpected result: out_byte 8'h%02h to_network %0b last %0b",
                   rsp_out_byte, rsp_to_network, rsp_last);
            fails++;
         end else begin
            want = expected_q.pop_front();
            results_checked++;
            if (rsp_to_network === 1'b1)
               net_results++;
            if (rsp_out_byte !== want.out_byte) begin
               $error("out_byte: expected 8'h%02h, actual 8'h%02h", want.out_byte, rsp_out_byte);
               fails++;
            end
            if (rsp_to_network !== want.to_net) begin
               $error("to_network: expected %0b, actual %0b", want.to_net, rsp_to_network);
               fails++;
            end
            if (rsp_last !== want.last) begin
               $error("last: expected %0b, actual %0b", want.last, rsp_last);
               fails++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("Run exceeded %0d cycles with %0d results outstanding.",
                  CYCLE_LIMIT, expected_q.size());
         $display("TEST FAILED");
         $finish;
      end
   end

   initial begin : stimulus
      int  i;
      int  random_items;
      bit  held;
      bit  paused;
      random_items = 0;
      held         = 1'b0;
      paused       = 1'b0;
      repeat (RESET_CYCLES) @(negedge clock);
      reset <= 1'b0;

      for (i = 0; i < OPENING_LEN; i++)
         offer_byte(opening[i].rx, opening[i].typed, opening[i].out_byte, opening[i].to_net);

      // A terminal-type request padded past capacity: the count must stick at capacity,
      // so the two stored bytes never read as a count of two and no answer goes out.
      pending_bytes.delete();
      pending_bytes.push_back(TN_IAC);
      pending_bytes.push_back(TN_SB);
      pending_bytes.push_back(OPT_TTYPE);
      pending_bytes.push_back(SUB_SEND);
      repeat (SUB_CAPACITY) pending_bytes.push_back(8'($urandom_range(0, 254)));
      pending_bytes.push_back(TN_IAC);
      pending_bytes.push_back(TN_SE);
      send_pending();

      while (random_items < RANDOM_ITEMS) begin
         sender_idles = ($urandom_range(0, 3) != 0);
         build_stream();
         send_pending();
         random_items += pending_bytes.size();
         if (!held && random_items >= RANDOM_ITEMS / 3) begin
            held     = 1'b1;
            hold_req = 1'b1;
         end
         if (!paused && random_items >= (2 * RANDOM_ITEMS) / 3) begin
            paused = 1'b1;
            drain_results();
         end
         if (random_items >= RANDOM_ITEMS - QUIET_ITEMS)
            quiet = 1'b1;
      end

      drain_results();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Checked %0d results (%0d back to the peer) from %0d received bytes.",
               results_checked, net_results, items_sent);
      $display("Streams held text, doubled IAC, option requests, subnegotiation answers,");
      $display("noise and an overfilled block.");
      if (fails == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
